>>> hw/rtl/wec_pkg.sv
// Shared types and constants for the windowed event correlator.
// No dependencies; used by every other file of the block.
`default_nettype none

package wec_pkg;

  localparam logic [1:0]  CMD_OBSERVE   = 2'd0;
  localparam logic [1:0]  CMD_CORRELATE = 2'd1;
  localparam logic [1:0]  CMD_CLEAR     = 2'd2;
  localparam logic [1:0]  CMD_RESERVED  = 2'd3;

  localparam logic [2:0]  KIND_HANDLE = 3'd1;
  localparam logic [2:0]  KIND_IMAGE  = 3'd2;
  localparam logic [2:0]  KIND_MEM_PE = 3'd3;
  localparam logic [2:0]  KIND_MEM    = 3'd4;

  localparam logic [31:0] WINDOW_MIN   = 32'd1000;
  localparam logic [9:0]  ANOMALY_GATE = 10'd800;
  localparam logic [6:0]  BOOST_CAP    = 7'd85;
  localparam logic [6:0]  W_TARGET     = 7'd18;  // same target plus temporal
  localparam logic [6:0]  W_SOURCE     = 7'd10;
  localparam logic [6:0]  W_H_MOD      = 7'd22;
  localparam logic [6:0]  W_H_MEM      = 7'd26;
  localparam logic [6:0]  W_M_MEM      = 7'd16;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] stamp_ms;
    logic [2:0]  event_kind;
    logic [9:0]  anomaly_milli;
    logic [31:0] src_pid;
    logic [63:0] src_birth;
    logic        src_valid;
    logic [31:0] tgt_pid;
    logic [63:0] tgt_birth;
    logic        tgt_valid;
  } in_word_t;

  typedef struct packed {
    logic        same_target;
    logic        same_source;
    logic        temporal_near;
    logic        handle_then_module;
    logic        handle_then_memory;
    logic        module_then_memory;
    logic [11:0] edge_count;
    logic [6:0]  boost_centi;
    logic [10:0] stored_count;
  } out_word_t;

  typedef struct packed {
    logic [47:0] time_ms;
    logic [2:0]  kind;
    logic [9:0]  anomaly;
    logic [31:0] src_pid;
    logic [63:0] src_birth;
    logic        src_valid;
    logic [31:0] tgt_pid;
    logic [63:0] tgt_birth;
    logic        tgt_valid;
  } entry_t;

  typedef enum logic [1:0] {
    OP_OBSERVE,
    OP_CORRELATE,
    OP_CLEAR,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e      op;
    in_word_t word;
  } task_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBS,
    ST_POP_RD,
    ST_POP_CHK,
    ST_SCAN,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/windowed_event_correlator.sv
// Windowed event correlator top level: window register, front queue, back engine.
// Depends on wec_pkg, wec_front and wec_engine.
// One word in, one word out. Observe writes the ring, then retires the oldest
// entry while it lies outside the window and more than one is held; correlate
// reads each held entry (one ring memory read a cycle); clear and the unused
// code go straight to the response. A two-word input queue and an output register
// let both sides stall independently. Window writes below 1000 ms are clamped.
`default_nettype none

module windowed_event_correlator #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  wec_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wec_pkg::out_word_t out_data_o
);

  logic [31:0]    window_q;
  logic           task_valid, task_ready;
  wec_pkg::task_t task_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= wec_pkg::WINDOW_MIN;
    end else if (cfg_we_i) begin
      window_q <= (cfg_wdata_i < wec_pkg::WINDOW_MIN) ? wec_pkg::WINDOW_MIN : cfg_wdata_i;
    end
  end

  wec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .task_valid_o (task_valid),
    .task_o       (task_w),
    .task_ready_i (task_ready)
  );

  wec_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .window_i     (window_q),
    .task_valid_i (task_valid),
    .task_i       (task_w),
    .task_ready_o (task_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/wec_front.sv
// Front end: accepts input words, decodes the command, holds a two-entry queue.
// Depends on wec_pkg.
`default_nettype none

module wec_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wec_pkg::in_word_t in_data_i,
  output logic             task_valid_o,
  output wec_pkg::task_t   task_o,
  input  logic             task_ready_i
);

  wec_pkg::task_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  wec_pkg::op_e   op;
  logic           push, pop;

  always_comb begin
    unique case (in_data_i.command)
      wec_pkg::CMD_OBSERVE:   op = wec_pkg::OP_OBSERVE;
      wec_pkg::CMD_CORRELATE: op = wec_pkg::OP_CORRELATE;
      wec_pkg::CMD_CLEAR:     op = wec_pkg::OP_CLEAR;
      default:                op = wec_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o   = (fill_q != 2'd2);
  assign task_valid_o = (fill_q != 2'd0);
  assign task_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = task_valid_o && task_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{op: op, word: in_data_i};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wec_engine.sv
// Back end: event ring memory, observe/retire and correlate sequencer, output register.
// Depends on wec_pkg.
`default_nettype none

module wec_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        window_i,
  input  logic               task_valid_i,
  input  wec_pkg::task_t     task_i,
  output logic               task_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output wec_pkg::out_word_t out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [CW-1:0] FULL_M1   = CW'(DEPTH - 1);

  wec_pkg::state_e state_q, state_d;
  wec_pkg::task_t  cur_q, cur_d;
  logic [AW-1:0]   head_q, head_d, ptr_q, ptr_d;
  logic [CW-1:0]   count_q, count_d, idx_q, idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic            st_q, st_d, ss_q, ss_d;
  logic            hmod_q, hmod_d, hmem_q, hmem_d, mmem_q, mmem_d;
  logic [11:0]     edges_q, edges_d;
  logic            out_vld_q, out_vld_d;
  wec_pkg::out_word_t out_q, out_d;

  wec_pkg::entry_t mem_q [DEPTH];
  wec_pkg::entry_t rdata_q, wdata;
  logic            mem_we, mem_re;
  logic [AW-1:0]   waddr, raddr;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  // entry evaluation against the current word
  wec_pkg::in_word_t w;
  logic [48:0] dt;
  logic        in_win, retire, tm, sm, mem_kind;
  logic        e_hmod, e_hmem, e_mmem;
  logic [AW-1:0] head1;
  logic [CW-1:0] count1;
  logic [CW:0]   wsum;
  logic [6:0]    boost_raw;
  logic          resp_go;

  assign w        = cur_q.word;
  assign dt       = {1'b0, w.stamp_ms} - {1'b0, rdata_q.time_ms};
  assign in_win   = !dt[48] && (dt[47:0] <= {16'd0, window_i});
  assign retire   = !dt[48] && (dt[47:0] > {16'd0, window_i});
  assign tm       = rdata_q.tgt_valid && w.tgt_valid && (rdata_q.tgt_pid == w.tgt_pid)
                    && (rdata_q.tgt_birth == w.tgt_birth);
  assign sm       = rdata_q.src_valid && w.src_valid && (rdata_q.src_pid == w.src_pid)
                    && (rdata_q.src_birth == w.src_birth);
  assign mem_kind = (w.event_kind == wec_pkg::KIND_MEM_PE) ||
                    (w.event_kind == wec_pkg::KIND_MEM);
  assign e_hmem   = in_win && tm && mem_kind && (rdata_q.kind == wec_pkg::KIND_HANDLE) && sm;
  assign e_mmem   = in_win && tm && mem_kind && (rdata_q.kind == wec_pkg::KIND_IMAGE)
                    && (rdata_q.anomaly >= wec_pkg::ANOMALY_GATE);
  assign e_hmod   = in_win && tm && (w.event_kind == wec_pkg::KIND_IMAGE)
                    && (rdata_q.kind == wec_pkg::KIND_HANDLE) && sm;

  // append slot: a full ring drops its oldest entry first
  always_comb begin
    head1  = (count_q >= FULL_CNT) ? slot_inc(head_q) : head_q;
    count1 = (count_q >= FULL_CNT) ? FULL_M1 : count_q;
    wsum   = (CW + 1)'(head1) + {1'b0, count1};
    if (wsum >= DEPTH_W) begin
      wsum = wsum - DEPTH_W;
    end
  end

  assign resp_go      = !out_vld_q || out_ready_i;
  assign task_ready_o = (state_q == wec_pkg::ST_IDLE);
  assign out_valid_o  = out_vld_q;
  assign out_data_o   = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wec_pkg::ST_IDLE: begin
        if (task_valid_i) begin
          unique case (task_i.op)
            wec_pkg::OP_OBSERVE:   state_d = wec_pkg::ST_OBS;
            wec_pkg::OP_CORRELATE: state_d = wec_pkg::ST_SCAN;
            default:               state_d = wec_pkg::ST_RESP;
          endcase
        end
      end
      wec_pkg::ST_OBS:     state_d = wec_pkg::ST_POP_RD;
      wec_pkg::ST_POP_RD:  state_d = (count_q <= CW'(1)) ? wec_pkg::ST_RESP
                                                         : wec_pkg::ST_POP_CHK;
      wec_pkg::ST_POP_CHK: state_d = retire ? wec_pkg::ST_POP_RD : wec_pkg::ST_RESP;
      wec_pkg::ST_SCAN:    state_d = (idx_q == count_q) ? wec_pkg::ST_RESP
                                                        : wec_pkg::ST_SCAN;
      wec_pkg::ST_RESP:    state_d = resp_go ? wec_pkg::ST_IDLE : wec_pkg::ST_RESP;
      default:             state_d = wec_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cur_d     = cur_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    ptr_d     = ptr_q;
    rd_vld_d  = 1'b0;
    st_d      = st_q;
    ss_d      = ss_q;
    hmod_d    = hmod_q;
    hmem_d    = hmem_q;
    mmem_d    = mmem_q;
    edges_d   = edges_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr     = wsum[AW-1:0];
    raddr     = head_q;
    boost_raw = '0;
    wdata     = '{time_ms: w.stamp_ms, kind: w.event_kind, anomaly: w.anomaly_milli,
                  src_pid: w.src_pid, src_birth: w.src_birth, src_valid: w.src_valid,
                  tgt_pid: w.tgt_pid, tgt_birth: w.tgt_birth, tgt_valid: w.tgt_valid};

    if (rd_vld_q) begin
      if (in_win && tm) st_d = 1'b1;
      if (in_win && sm) ss_d = 1'b1;
      if (e_hmod) hmod_d = 1'b1;
      if (e_hmem) hmem_d = 1'b1;
      if (e_mmem) mmem_d = 1'b1;
      edges_d = edges_q + 12'(e_hmod) + 12'(e_hmem) + 12'(e_mmem);
    end

    unique case (state_q)
      wec_pkg::ST_IDLE: begin
        if (task_valid_i) begin
          cur_d   = task_i;
          idx_d   = '0;
          ptr_d   = head_q;
          st_d    = 1'b0;
          ss_d    = 1'b0;
          hmod_d  = 1'b0;
          hmem_d  = 1'b0;
          mmem_d  = 1'b0;
          edges_d = '0;
          if (task_i.op == wec_pkg::OP_CLEAR) begin
            head_d  = '0;
            count_d = '0;
          end
        end
      end
      wec_pkg::ST_OBS: begin
        mem_we  = 1'b1;
        head_d  = head1;
        count_d = count1 + CW'(1);
      end
      wec_pkg::ST_POP_RD: begin
        mem_re = (count_q > CW'(1));
        raddr  = head_q;
      end
      wec_pkg::ST_POP_CHK: begin
        if (retire) begin
          head_d  = slot_inc(head_q);
          count_d = count_q - CW'(1);
        end
      end
      wec_pkg::ST_SCAN: begin
        if (idx_q != count_q) begin
          mem_re   = 1'b1;
          raddr    = ptr_q;
          rd_vld_d = 1'b1;
          idx_d    = idx_q + CW'(1);
          ptr_d    = slot_inc(ptr_q);
        end
      end
      wec_pkg::ST_RESP: begin
        if (resp_go) begin
          out_vld_d = 1'b1;
          out_d     = '0;
          out_d.stored_count = 11'(count_q);
          if (cur_q.op == wec_pkg::OP_CORRELATE) begin
            if (st_q)   boost_raw = boost_raw + wec_pkg::W_TARGET;
            if (ss_q)   boost_raw = boost_raw + wec_pkg::W_SOURCE;
            if (hmod_q) boost_raw = boost_raw + wec_pkg::W_H_MOD;
            if (hmem_q) boost_raw = boost_raw + wec_pkg::W_H_MEM;
            if (mmem_q) boost_raw = boost_raw + wec_pkg::W_M_MEM;
            out_d.same_target        = st_q;
            out_d.same_source        = ss_q;
            out_d.temporal_near      = st_q;
            out_d.handle_then_module = hmod_q;
            out_d.handle_then_memory = hmem_q;
            out_d.module_then_memory = mmem_q;
            out_d.edge_count         = edges_q;
            out_d.boost_centi = (boost_raw > wec_pkg::BOOST_CAP) ? wec_pkg::BOOST_CAP
                                                                 : boost_raw;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wec_pkg::ST_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    idx_q   <= idx_d;
    ptr_q   <= ptr_d;
    st_q    <= st_d;
    ss_q    <= ss_d;
    hmod_q  <= hmod_d;
    hmem_q  <= hmem_d;
    mmem_q  <= mmem_d;
    edges_q <= edges_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wec_checker.sv
// Port-level checks for the windowed event correlator, bound to the top level.
// Depends on wec_pkg and windowed_event_correlator.
`default_nettype none

module wec_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input wec_pkg::out_word_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word dropped or changed while stalled");

  a_boost_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.boost_centi <= wec_pkg::BOOST_CAP
                    && out_data_o.temporal_near == out_data_o.same_target)
    else $error("boost over cap or temporal flag mismatch");

  a_need_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.same_target |-> !out_data_o.handle_then_module
      && !out_data_o.handle_then_memory && !out_data_o.module_then_memory
      && out_data_o.edge_count == 12'd0)
    else $error("sequence flag without target match");

  a_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.edge_count == 12'd0 |-> !out_data_o.handle_then_module
      && !out_data_o.handle_then_memory && !out_data_o.module_then_memory)
    else $error("sequence flag without edge");

endmodule

bind windowed_event_correlator wec_checker u_wec_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
